// ===== src/tria_pkg.sv =====
`default_nettype none

package tria_pkg;

  // Input item: one interval
  typedef struct packed {
    logic [15:0] start_time;
    logic [15:0] finish_time;
    logic        last_interval;
  } in_item_t;

  // Result item
  typedef struct packed {
    logic [5:0] interval_index;
    logic       resource;
    logic       impossible;
    logic       last_result;
  } out_item_t;

  // Resource codes
  localparam logic RES_FIRST  = 1'b0;
  localparam logic RES_SECOND = 1'b1;

  // Front queue geometry
  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = 2;
  localparam int QCNT_W      = 3;

  // Controls from the back sequencer to the sorted cell chain
  typedef struct packed {
    logic insert;
    logic shift;
    logic clear;
  } chain_ctl_t;

endpackage

`default_nettype wire

// ===== src/tria_queue.sv =====
`default_nettype none

module tria_queue
  import tria_pkg::*;
(
  input  wire logic     clk,
  input  wire logic     rst,
  input  wire logic     push,
  input  wire in_item_t push_item,
  output logic          full,
  input  wire logic     pop,
  output logic          empty,
  output in_item_t      head
);

  in_item_t            slots [QUEUE_DEPTH];
  logic [QPTR_W-1:0]   wr_ptr;
  logic [QPTR_W-1:0]   rd_ptr;
  logic [QCNT_W-1:0]   fill;
  logic                do_push;
  logic                do_pop;

  assign full    = (fill == QCNT_W'(QUEUE_DEPTH));
  assign empty   = (fill == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign head    = slots[rd_ptr];

  // Pointers and fill level
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (do_push) wr_ptr <= wr_ptr + 1'b1;
      if (do_pop)  rd_ptr <= rd_ptr + 1'b1;
      if (do_push && !do_pop)      fill <= fill + 1'b1;
      else if (!do_push && do_pop) fill <= fill - 1'b1;
    end
  end

  // Item storage
  always_ff @(posedge clk) begin
    if (do_push) slots[wr_ptr] <= push_item;
  end

endmodule

`default_nettype wire

// ===== src/tria_chain.sv =====
`default_nettype none

module tria_chain
  import tria_pkg::*;
#(
  parameter int MAX_INTERVALS = 64,
  parameter int TIME_BITS     = 16
) (
  input  wire logic                              clk,
  input  wire logic                              rst,
  input  wire chain_ctl_t                        ctl,
  input  wire logic [TIME_BITS-1:0]              ins_start,
  input  wire logic [TIME_BITS-1:0]              ins_finish,
  output logic [TIME_BITS-1:0]                   head_start,
  output logic [TIME_BITS-1:0]                   head_finish,
  output logic [$clog2(MAX_INTERVALS)-1:0]       head_index,
  output logic [$clog2(MAX_INTERVALS+1)-1:0]     count
);

  localparam int IDX_W = $clog2(MAX_INTERVALS);
  localparam int CNT_W = $clog2(MAX_INTERVALS + 1);

  logic [TIME_BITS-1:0] cs [MAX_INTERVALS];
  logic [TIME_BITS-1:0] cf [MAX_INTERVALS];
  logic [IDX_W-1:0]     ci [MAX_INTERVALS];
  logic [MAX_INTERVALS-1:0] moves;
  logic                 do_ins;

  assign do_ins      = ctl.insert && (count < CNT_W'(MAX_INTERVALS));
  assign head_start  = cs[0];
  assign head_finish = cf[0];
  assign head_index  = ci[0];

  // Each occupied cell checks whether the new interval sorts ahead of it
  always_comb begin
    for (int i = 0; i < MAX_INTERVALS; i++) begin
      moves[i] = (CNT_W'(i) < count) &&
                 ((ins_start < cs[i]) || ((ins_start == cs[i]) && (ins_finish < cf[i])));
    end
  end

  // Occupancy; a full chain drops further intervals
  always_ff @(posedge clk) begin
    if (rst || ctl.clear) begin
      count <= '0;
    end else if (do_ins) begin
      count <= count + 1'b1;
    end
  end

  // Cells: insert shifts the tail right, walk shifts everything left
  for (genvar g = 0; g < MAX_INTERVALS; g++) begin : g_cell
    logic take_new;
    logic take_left;
    logic from_right;
    logic [TIME_BITS-1:0] rs, rf;
    logic [IDX_W-1:0]     ri;

    if (g == 0) begin : g_first
      assign take_left = 1'b0;
    end else begin : g_rest
      assign take_left = moves[g-1];
    end
    assign take_new = moves[g] || (CNT_W'(g) == count);

    if (g < MAX_INTERVALS - 1) begin : g_inner
      assign from_right = 1'b1;
      assign rs = cs[g+1];
      assign rf = cf[g+1];
      assign ri = ci[g+1];
    end else begin : g_tail
      assign from_right = 1'b0;
      assign rs = cs[g];
      assign rf = cf[g];
      assign ri = ci[g];
    end

    always_ff @(posedge clk) begin
      if (do_ins) begin
        if (take_new) begin
          if (take_left) begin
            cs[g] <= cs[g-((g > 0) ? 1 : 0)];
            cf[g] <= cf[g-((g > 0) ? 1 : 0)];
            ci[g] <= ci[g-((g > 0) ? 1 : 0)];
          end else begin
            cs[g] <= ins_start;
            cf[g] <= ins_finish;
            ci[g] <= count[IDX_W-1:0];
          end
        end
      end else if (ctl.shift && from_right) begin
        cs[g] <= rs;
        cf[g] <= rf;
        ci[g] <= ri;
      end
    end
  end

endmodule

`default_nettype wire

// ===== src/tria_back.sv =====
`default_nettype none

module tria_back
  import tria_pkg::*;
#(
  parameter int MAX_INTERVALS = 64,
  parameter int TIME_BITS     = 16
) (
  input  wire logic                              clk,
  input  wire logic                              rst,
  // front queue side
  input  wire logic                              q_empty,
  input  wire in_item_t                          q_head,
  output logic                                   q_pop,
  // sorted chain side
  output chain_ctl_t                             ctl,
  output logic [TIME_BITS-1:0]                   ins_start,
  output logic [TIME_BITS-1:0]                   ins_finish,
  input  wire logic [TIME_BITS-1:0]              head_start,
  input  wire logic [TIME_BITS-1:0]              head_finish,
  input  wire logic [$clog2(MAX_INTERVALS)-1:0]  head_index,
  input  wire logic [$clog2(MAX_INTERVALS+1)-1:0] count,
  // results
  output logic                                   result_valid,
  output out_item_t                              result
);

  localparam int IDX_W = $clog2(MAX_INTERVALS);
  localparam int CNT_W = $clog2(MAX_INTERVALS + 1);

  localparam logic [1:0] ST_LOAD   = 2'd0;
  localparam logic [1:0] ST_ASSIGN = 2'd1;
  localparam logic [1:0] ST_EMIT   = 2'd2;

  logic [1:0]           state;
  logic [IDX_W-1:0]     step;
  logic [TIME_BITS-1:0] first_busy_until;
  logic [TIME_BITS-1:0] second_busy_until;
  logic                 assign_mem [MAX_INTERVALS];
  logic                 rd_bit;
  logic [IDX_W-1:0]     out_index;
  logic                 out_last;
  logic                 out_fail;
  logic                 step_last;
  logic                 first_free;
  logic                 second_free;
  logic                 walk_fail;
  logic                 set_done;

  assign step_last   = ((CNT_W'(step) + 1'b1) == count);
  assign first_free  = (first_busy_until <= head_start);
  assign second_free = (second_busy_until <= head_start);
  assign walk_fail   = (state == ST_ASSIGN) && !first_free && !second_free;
  assign set_done    = walk_fail || ((state == ST_EMIT) && step_last);

  // Feed the chain from the queue while collecting a set
  assign q_pop      = (state == ST_LOAD) && !q_empty;
  assign ins_start  = TIME_BITS'(q_head.start_time);
  assign ins_finish = TIME_BITS'(q_head.finish_time);
  assign ctl.insert = q_pop;
  assign ctl.shift  = (state == ST_ASSIGN);
  assign ctl.clear  = set_done;

  // Sequencer: collect, walk sorted order, emit in arrival order
  always_ff @(posedge clk) begin
    if (rst) begin
      state             <= ST_LOAD;
      step              <= '0;
      first_busy_until  <= '0;
      second_busy_until <= '0;
    end else begin
      case (state)
        ST_LOAD: begin
          step <= '0;
          if (q_pop && q_head.last_interval) state <= ST_ASSIGN;
        end
        ST_ASSIGN: begin
          if (walk_fail) begin
            state             <= ST_LOAD;
            first_busy_until  <= '0;
            second_busy_until <= '0;
          end else begin
            if (first_free) first_busy_until  <= head_finish;
            else            second_busy_until <= head_finish;
            if (step_last) begin
              state <= ST_EMIT;
              step  <= '0;
            end else begin
              step <= step + 1'b1;
            end
          end
        end
        ST_EMIT: begin
          if (step_last) begin
            state             <= ST_LOAD;
            first_busy_until  <= '0;
            second_busy_until <= '0;
          end else begin
            step <= step + 1'b1;
          end
        end
        default: state <= ST_LOAD;
      endcase
    end
  end

  // Resource per arrival index: written during the walk, read during emit
  always_ff @(posedge clk) begin
    if ((state == ST_ASSIGN) && !walk_fail) begin
      assign_mem[head_index] <= first_free ? RES_FIRST : RES_SECOND;
    end
    rd_bit <= assign_mem[step];
  end

  // Result strobe and side fields, aligned with the memory read
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else begin
      result_valid <= walk_fail || (state == ST_EMIT);
    end
  end

  always_ff @(posedge clk) begin
    out_index <= step;
    out_last  <= step_last;
    out_fail  <= walk_fail;
  end

  always_comb begin
    if (out_fail) begin
      result.interval_index = '0;
      result.resource       = RES_FIRST;
      result.impossible     = 1'b1;
      result.last_result    = 1'b1;
    end else begin
      result.interval_index = 6'(out_index);
      result.resource       = rd_bit;
      result.impossible     = 1'b0;
      result.last_result    = out_last;
    end
  end

endmodule

`default_nettype wire

// ===== src/two_resource_interval_assigner_top.sv =====
`default_nettype none

// Two-resource interval assigner.
// Input: assert start with an interval on item; it is taken at a clock edge
// where start is high and busy is low. item.last_interval closes the set.
// Intervals beyond MAX_INTERVALS in one set are dropped (last still closes).
// Output: result_valid strobes for one cycle per result; results cannot be
// held off. A good set gives one result per interval in arrival order, the
// last flagged last_result; an unassignable set gives one impossible result.
// Throughput: a four-entry front queue takes an item per cycle while not
// full; the back inserts one interval per cycle into a sorted cell chain
// while it collects a set and the queue holds items. busy rises only when
// that queue is full, mostly while the back walks or emits a set.
// After the last interval is inserted, the back makes the greedy walk over
// the chain, then emits the results through the registered read of the
// assignment memory. The queue lets the next set be loaded meanwhile.
// Reset (rst, synchronous) empties the queue and the chain and clears both
// resource busy-until times.

module two_resource_interval_assigner_top
  import tria_pkg::*;
#(
  parameter int MAX_INTERVALS = 64,
  parameter int TIME_BITS     = 16
) (
  input  wire logic      clk,
  input  wire logic      rst,
  input  wire logic      start,
  input  wire in_item_t  item,
  output logic           busy,
  output logic           result_valid,
  output out_item_t      result
);

  localparam int IDX_W = $clog2(MAX_INTERVALS);
  localparam int CNT_W = $clog2(MAX_INTERVALS + 1);

  logic                 q_empty;
  logic                 q_pop;
  in_item_t             q_head;
  chain_ctl_t           ctl;
  logic [TIME_BITS-1:0] ins_start;
  logic [TIME_BITS-1:0] ins_finish;
  logic [TIME_BITS-1:0] head_start;
  logic [TIME_BITS-1:0] head_finish;
  logic [IDX_W-1:0]     head_index;
  logic [CNT_W-1:0]     count;

  // Front: item intake
  tria_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (start),
    .push_item (item),
    .full      (busy),
    .pop       (q_pop),
    .empty     (q_empty),
    .head      (q_head)
  );

  // Sorted storage of the open set
  tria_chain #(
    .MAX_INTERVALS (MAX_INTERVALS),
    .TIME_BITS     (TIME_BITS)
  ) u_chain (
    .clk         (clk),
    .rst         (rst),
    .ctl         (ctl),
    .ins_start   (ins_start),
    .ins_finish  (ins_finish),
    .head_start  (head_start),
    .head_finish (head_finish),
    .head_index  (head_index),
    .count       (count)
  );

  // Back: greedy assignment and result emission
  tria_back #(
    .MAX_INTERVALS (MAX_INTERVALS),
    .TIME_BITS     (TIME_BITS)
  ) u_back (
    .clk          (clk),
    .rst          (rst),
    .q_empty      (q_empty),
    .q_head       (q_head),
    .q_pop        (q_pop),
    .ctl          (ctl),
    .ins_start    (ins_start),
    .ins_finish   (ins_finish),
    .head_start   (head_start),
    .head_finish  (head_finish),
    .head_index   (head_index),
    .count        (count),
    .result_valid (result_valid),
    .result       (result)
  );

endmodule

`default_nettype wire

// ===== sim/two_resource_interval_assigner_top_test.sv =====
`timescale 1ns / 100ps

import tria_pkg::*;

// Holds the open interval set, works out the greedy two-resource assignment
// when a set closes, and checks results against that.
class interval_scoreboard;
  localparam int SET_CAPACITY = 64;

  in_item_t  open_set[$];
  out_item_t expected_results[$];
  int        errors;
  int        results_checked;
  int        sets_closed;
  int        impossible_sets;
  int        dropped_intervals;

  // Accepted interval: store it, and on the closing one predict the results
  function void note_interval(in_item_t it);
    int        order[$];
    int        n, i, j, k;
    logic [15:0] first_until, second_until;
    logic      chosen[SET_CAPACITY];
    bit        blocked;
    out_item_t res;
    if (open_set.size() < SET_CAPACITY) open_set.push_back(it);
    else dropped_intervals++;
    if (!it.last_interval) return;

    // Order by start, then finish; arrival order breaks ties (stable insert)
    n = open_set.size();
    for (i = 0; i < n; i++) begin
      j = order.size();
      while (j > 0 &&
             (open_set[order[j-1]].start_time > open_set[i].start_time ||
              (open_set[order[j-1]].start_time == open_set[i].start_time &&
               open_set[order[j-1]].finish_time > open_set[i].finish_time)))
        j--;
      order.insert(j, i);
    end

    // Greedy walk: first resource if free, else second, else give up
    first_until  = '0;
    second_until = '0;
    blocked      = 1'b0;
    for (i = 0; i < n && !blocked; i++) begin
      k = order[i];
      if (first_until <= open_set[k].start_time) begin
        first_until = open_set[k].finish_time;
        chosen[k]   = RES_FIRST;
      end else if (second_until <= open_set[k].start_time) begin
        second_until = open_set[k].finish_time;
        chosen[k]    = RES_SECOND;
      end else begin
        blocked = 1'b1;
      end
    end

    if (blocked) begin
      res.interval_index = '0;
      res.resource       = RES_FIRST;
      res.impossible     = 1'b1;
      res.last_result    = 1'b1;
      expected_results.push_back(res);
      impossible_sets++;
    end else begin
      for (i = 0; i < n; i++) begin
        res.interval_index = i[5:0];
        res.resource       = chosen[i];
        res.impossible     = 1'b0;
        res.last_result    = (i == n - 1);
        expected_results.push_back(res);
      end
    end
    sets_closed++;
    open_set.delete();
  endfunction

  // Result strobe: compare with the oldest pending expectation
  function void check_result(out_item_t got);
    out_item_t want;
    if (expected_results.size() == 0) begin
      errors++;
      $display("%0t: unexpected result: expected none, actual index=%0d resource=%0d %s%0d last=%0d",
               $time, got.interval_index, got.resource, "impossible=", got.impossible,
               got.last_result);
      return;
    end
    want = expected_results.pop_front();
    results_checked++;
    if (got.interval_index !== want.interval_index || got.resource !== want.resource ||
        got.impossible !== want.impossible || got.last_result !== want.last_result) begin
      errors++;
      $display("%0t: result mismatch: expected index=%0d resource=%0d impossible=%0d last=%0d",
               $time, want.interval_index, want.resource, want.impossible,
               want.last_result);
      $display("%0t:                  actual index=%0d resource=%0d impossible=%0d last=%0d",
               $time, got.interval_index, got.resource, got.impossible,
               got.last_result);
    end
  endfunction
endclass

module two_resource_interval_assigner_top_test;
  localparam int SET_CAPACITY   = 64;
  localparam int ITEM_TARGET    = 470;
  localparam int WATCHDOG_LIMIT = 3000;
  localparam int DRAIN_CYCLES   = 3 * SET_CAPACITY + 40;

  typedef enum int {SET_CHAINED, SET_NOISE, SET_BROKEN} set_kind_e;

  logic      clk   = 1'b0;
  logic      rst   = 1'b1;
  logic      start = 1'b0;
  in_item_t  item  = '0;
  logic      busy;
  logic      result_valid;
  out_item_t result;

  interval_scoreboard sb = new();
  int items_sent   = 0;
  int burst_left   = 0;
  int stall_cycles = 0;

  two_resource_interval_assigner_top #(
    .MAX_INTERVALS(SET_CAPACITY),
    .TIME_BITS    (16)
  ) dut (
    .clk         (clk),
    .rst         (rst),
    .start       (start),
    .item        (item),
    .busy        (busy),
    .result_valid(result_valid),
    .result      (result)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Monitor: accepted items and results, plus the no-progress watchdog
  always @(posedge clk) begin
    if (!rst) begin
      if (start && !busy) sb.note_interval(item);
      if (result_valid) sb.check_result(result);
      if ((start && !busy) || result_valid) begin
        stall_cycles <= 0;
      end else if (stall_cycles == WATCHDOG_LIMIT) begin
        $display("%0t: no progress for %0d cycles, %0d results outstanding",
                 $time, WATCHDOG_LIMIT, sb.expected_results.size());
        $display("Test completed with failures");
        $finish;
      end else begin
        stall_cycles <= stall_cycles + 1;
      end
    end
  end

  function automatic in_item_t make_interval(int s, int f, bit last);
    in_item_t it;
    it.start_time    = s[15:0];
    it.finish_time   = f[15:0];
    it.last_interval = last;
    return it;
  endfunction

  // Present one item, hold it until taken, then maybe open a gap
  task automatic send_interval(input in_item_t it);
    start <= 1'b1;
    item  <= it;
    @(posedge clk);
    while (busy) @(posedge clk);
    items_sent++;
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      start <= 1'b0;
      repeat ($urandom_range(0, 5) == 0 ? $urandom_range(13, 30) : $urandom_range(1, 12))
        @(posedge clk);
      burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(60, 150)
                                               : $urandom_range(0, 30);
    end
  endtask

  // Build one set in arrival order; only the final item closes it
  task automatic make_set(output in_item_t s[$], input int n, input set_kind_e kind);
    int       t_first, t_second, st, fin, k, j;
    bit       pick;
    in_item_t tmp;
    s.delete();
    t_first  = $urandom_range(0, 20000);
    t_second = t_first + $urandom_range(0, 50);
    for (k = 0; k < n; k++) begin
      if (kind == SET_NOISE) begin
        if ($urandom_range(0, 1) == 0) begin
          st  = $urandom() & 16'hffff;
          fin = $urandom() & 16'hffff;
        end else begin
          st  = $urandom_range(0, 40);
          fin = st + $urandom_range(0, 20) - 3;
          if (fin < 0) fin = 0;
        end
      end else begin
        // two non-overlapping chains, touching now and then
        pick = 1'($urandom_range(0, 1));
        st   = (pick ? t_second : t_first) +
               (($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 200));
        fin  = st + $urandom_range(0, 600);
        if (st > 65535) st = 65535;
        if (fin > 65535) fin = 65535;
        if (pick) t_second = fin;
        else t_first = fin;
      end
      s.push_back(make_interval(st, fin, 1'b0));
    end
    if (kind == SET_BROKEN) begin
      k = $urandom_range(0, n - 1);
      if ($urandom_range(0, 1) == 0) begin
        tmp = s[k];
        s[k].start_time  = tmp.finish_time;
        s[k].finish_time = tmp.start_time;
      end else begin
        s[k].start_time  = 16'(s[$urandom_range(0, n - 1)].start_time +
                               $urandom_range(0, 30));
        s[k].finish_time = 16'(s[k].start_time + $urandom_range(0, 800));
      end
    end
    // shuffle arrival order
    for (k = n - 1; k > 0; k--) begin
      j    = $urandom_range(0, k);
      tmp  = s[k];
      s[k] = s[j];
      s[j] = tmp;
    end
    s[n-1].last_interval = 1'b1;
  endtask

  initial begin
    in_item_t  set_items[$];
    set_kind_e kind;
    int        set_no, n, r, k;

    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed: one-interval set at zero
    send_interval(make_interval(0, 0, 1));
    // Field extremes
    send_interval(make_interval(65535, 65535, 0));
    send_interval(make_interval(0, 65535, 1));
    send_interval(make_interval(16'haaaa, 16'h5555, 0));
    send_interval(make_interval(16'h5555, 16'haaaa, 1));
    // Touching intervals share the first resource
    send_interval(make_interval(10, 20, 0));
    send_interval(make_interval(0, 10, 0));
    send_interval(make_interval(20, 30, 1));
    // Overlap pushes one onto the second resource
    send_interval(make_interval(0, 10, 0));
    send_interval(make_interval(5, 15, 0));
    send_interval(make_interval(10, 12, 1));
    // Three-way overlap: no assignment exists
    send_interval(make_interval(0, 10, 0));
    send_interval(make_interval(1, 9, 0));
    send_interval(make_interval(2, 8, 1));
    // Finish below start is taken as given
    send_interval(make_interval(100, 50, 0));
    send_interval(make_interval(60, 70, 0));
    send_interval(make_interval(55, 56, 1));
    // Equal starts: ordered by finish, then arrival
    send_interval(make_interval(5, 9, 0));
    send_interval(make_interval(5, 7, 0));
    send_interval(make_interval(9, 12, 0));
    send_interval(make_interval(7, 9, 1));

    // Random sets, mostly assignable; a few at and past capacity
    set_no = 0;
    while (items_sent < ITEM_TARGET) begin
      r = $urandom_range(0, 99);
      kind = (r < 70) ? SET_CHAINED : (r < 85) ? SET_NOISE : SET_BROKEN;
      if (set_no == 4) begin
        n = SET_CAPACITY;
        kind = SET_CHAINED;
      end else if (set_no == 9 || set_no == 25) begin
        n = $urandom_range(SET_CAPACITY + 1, SET_CAPACITY + 6);
        kind = SET_CHAINED;
      end else if ($urandom_range(0, 29) == 0) begin
        n = $urandom_range(11, 40);
      end else begin
        n = $urandom_range(1, 10);
      end
      make_set(set_items, n, kind);
      for (k = 0; k < n; k++) send_interval(set_items[k]);
      set_no++;
    end
    start <= 1'b0;

    // Drain: wait for every expected result, then watch for strays
    @(posedge clk);
    while (sb.expected_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Sent %0d intervals in %0d sets: %0d impossible, %0d dropped past capacity.",
             items_sent, sb.sets_closed, sb.impossible_sets, sb.dropped_intervals);
    $display("Checked %0d results, %0d errors, %0d results still pending.",
             sb.results_checked, sb.errors, sb.expected_results.size());
    if (sb.errors == 0 && sb.expected_results.size() == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end
endmodule
